>>> hw/rtl/iaf_pkg.sv
// types, microcode program and character helpers for the integer ascii formatter
`default_nettype none
package iaf_pkg;

	localparam int PcW = 4;
	localparam int CntW = 5;
	localparam int IterW = 5;

	// conversion codes
	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_PTR = 3'd4;

	// sign flag codes
	localparam logic [1:0] SF_SPACE = 2'd1;
	localparam logic [1:0] SF_PLUS = 2'd2;

	localparam logic [CntW-1:0] DEC_DIGITS = 5'd10;
	localparam logic [CntW-1:0] HEX_DIGITS = 5'd16;
	localparam logic [IterW-1:0] DABBLE_LAST = 5'd31;

	// emit kinds
	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_CONST = 2'd1;
	localparam logic [1:0] E_SIGN = 2'd2;
	localparam logic [1:0] E_DIGIT = 2'd3;

	// datapath operations
	localparam logic [1:0] DP_NONE = 2'd0;
	localparam logic [1:0] DP_DABBLE = 2'd1;
	localparam logic [1:0] DP_SKIP = 2'd2;
	localparam logic [1:0] DP_SHIFT = 2'd3;

	// branch conditions
	localparam logic [2:0] C_ALWAYS = 3'd0;
	localparam logic [2:0] C_INPUT = 3'd1;
	localparam logic [2:0] C_ITER_MORE = 3'd2;
	localparam logic [2:0] C_SKIP = 3'd3;
	localparam logic [2:0] C_MORE = 3'd4;
	localparam logic [2:0] C_ZERO = 3'd5;

	// program addresses
	localparam logic [PcW-1:0] A_FETCH = 4'd0;
	localparam logic [PcW-1:0] A_DABBLE = 4'd1;
	localparam logic [PcW-1:0] A_SIGN = 4'd2;
	localparam logic [PcW-1:0] A_SKIP = 4'd3;
	localparam logic [PcW-1:0] A_DIGIT = 4'd4;
	localparam logic [PcW-1:0] A_PTR = 4'd5;
	localparam logic [PcW-1:0] A_PTR_0 = 4'd6;
	localparam logic [PcW-1:0] A_PTR_X = 4'd7;
	localparam logic [PcW-1:0] A_NIL_0 = 4'd8;
	localparam logic [PcW-1:0] A_NIL_1 = 4'd9;
	localparam logic [PcW-1:0] A_NIL_2 = 4'd10;
	localparam logic [PcW-1:0] A_NIL_3 = 4'd11;
	localparam logic [PcW-1:0] A_NIL_4 = 4'd12;

	typedef struct packed {
		logic [1:0]     emit;
		logic [7:0]     chr;
		logic           last;
		logic [1:0]     dp;
		logic [2:0]     cond;
		logic [PcW-1:0] target;
		logic [PcW-1:0] alt;
	} ctl_t;

	typedef struct packed {
		logic       in_valid;
		logic [2:0] op;
		logic       iter_last;
		logic       skip;
		logic       more;
		logic       val_zero;
		logic       out_free;
		logic       pre_v;
	} stat_t;

	typedef struct packed {
		logic       accept;
		logic       go;
		logic       emit_act;
		logic [1:0] emit;
		logic [7:0] chr;
		logic       last;
		logic [1:0] dp;
	} cmd_t;

	function automatic ctl_t mkw(input logic [1:0] emit, input logic [7:0] chr,
		input logic last, input logic [1:0] dp, input logic [2:0] cond,
		input logic [PcW-1:0] target, input logic [PcW-1:0] alt);
		ctl_t w;
		w.emit = emit;
		w.chr = chr;
		w.last = last;
		w.dp = dp;
		w.cond = cond;
		w.target = target;
		w.alt = alt;
		return w;
	endfunction

	// control store
	function automatic ctl_t ucode(input logic [PcW-1:0] a);
		ctl_t w;
		case (a)
			A_FETCH:  w = mkw(E_NONE, 8'h00, 1'b0, DP_NONE, C_INPUT, A_FETCH, A_FETCH);
			A_DABBLE: w = mkw(E_NONE, 8'h00, 1'b0, DP_DABBLE, C_ITER_MORE, A_DABBLE, A_SIGN);
			A_SIGN:   w = mkw(E_SIGN, 8'h00, 1'b0, DP_NONE, C_ALWAYS, A_SKIP, A_SKIP);
			A_SKIP:   w = mkw(E_NONE, 8'h00, 1'b0, DP_SKIP, C_SKIP, A_SKIP, A_DIGIT);
			A_DIGIT:  w = mkw(E_DIGIT, 8'h00, 1'b0, DP_SHIFT, C_MORE, A_DIGIT, A_FETCH);
			A_PTR:    w = mkw(E_NONE, 8'h00, 1'b0, DP_NONE, C_ZERO, A_NIL_0, A_PTR_0);
			A_PTR_0:  w = mkw(E_CONST, 8'h30, 1'b0, DP_NONE, C_ALWAYS, A_PTR_X, A_PTR_X);
			A_PTR_X:  w = mkw(E_CONST, 8'h78, 1'b0, DP_NONE, C_ALWAYS, A_SKIP, A_SKIP);
			A_NIL_0:  w = mkw(E_CONST, 8'h28, 1'b0, DP_NONE, C_ALWAYS, A_NIL_1, A_NIL_1);
			A_NIL_1:  w = mkw(E_CONST, 8'h6e, 1'b0, DP_NONE, C_ALWAYS, A_NIL_2, A_NIL_2);
			A_NIL_2:  w = mkw(E_CONST, 8'h69, 1'b0, DP_NONE, C_ALWAYS, A_NIL_3, A_NIL_3);
			A_NIL_3:  w = mkw(E_CONST, 8'h6c, 1'b0, DP_NONE, C_ALWAYS, A_NIL_4, A_NIL_4);
			A_NIL_4:  w = mkw(E_CONST, 8'h29, 1'b1, DP_NONE, C_ALWAYS, A_FETCH, A_FETCH);
			default:  w = mkw(E_NONE, 8'h00, 1'b0, DP_NONE, C_ALWAYS, A_FETCH, A_FETCH);
		endcase
		return w;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = 8'h30 + {4'b0, d};
		end else begin
			r = (up ? 8'h41 : 8'h61) + {4'b0, d} - 8'd10;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/integer_ascii_formatter.sv
// integer ascii formatter: digit datapath, output register and sequencer instance
// steps: an accept step, then decimal codes run the shift-add-3 loop over the 32 low input bits,
// a sign step, the skip loop over leading zero digits and the digit loop that emits each character;
// hex codes go straight to the skip loop, and pointer codes emit "0x" or "(nil)" first
// throughput: one item in work at a time; the next input transfer is taken in the fetch step
// after the last character is in the output register; each character step waits while the
// output register is full. reset clears the step counter and the output valid
`default_nettype none
module integer_ascii_formatter
	import iaf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // [63:0] value
	input  wire  [4:0]  s_tuser,   // [2:0] operation, [4:3] sign_flag
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] character
	output logic        m_tlast
);

	stat_t stat;
	cmd_t  cmd;
	logic  fetch;

	logic [63:0]      dig_q;
	logic [31:0]      bin_q;
	logic [CntW-1:0]  cnt_q;
	logic [IterW-1:0] it_q;
	logic             upper_q;
	logic [7:0]       pre_q;
	logic             pre_v_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	logic [2:0]  in_op;
	logic [1:0]  in_flag;
	logic [31:0] low;
	logic        neg;
	logic [39:0] bcd_adj;
	logic        emit_fire;
	logic [7:0]  emit_chr;
	logic        emit_last;

	assign in_op = s_tuser[2:0];
	assign in_flag = s_tuser[4:3];
	assign low = s_tdata[31:0];
	assign neg = (in_op == OP_SDEC) && low[31];

	assign stat.in_valid = s_tvalid;
	assign stat.op = in_op;
	assign stat.iter_last = (it_q == DABBLE_LAST);
	assign stat.skip = (dig_q[63:60] == 4'd0) && (cnt_q > 5'd1);
	assign stat.more = (cnt_q != 5'd1);
	assign stat.val_zero = (dig_q == 64'd0);
	assign stat.out_free = !m_tvalid_q || m_tready;
	assign stat.pre_v = pre_v_q;

	iaf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.fetch  (fetch),
		.cmd    (cmd)
	);

	assign s_tready = fetch;

	// add 3 to every bcd digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < 10; i++) begin
			if (dig_q[24+4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = dig_q[24+4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = dig_q[24+4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (in_op == OP_SDEC || in_op == OP_UDEC) begin
				dig_q <= 64'd0;
				cnt_q <= DEC_DIGITS;
			end else begin
				dig_q <= s_tdata;
				cnt_q <= HEX_DIGITS;
			end
			bin_q <= neg ? (32'd0 - low) : low;
			it_q <= '0;
			upper_q <= (in_op == OP_HEXU);
			pre_v_q <= neg || ((in_op == OP_SDEC) && (low != 32'd0) &&
				(in_flag == SF_SPACE || in_flag == SF_PLUS));
			if (neg) begin
				pre_q <= 8'h2d;
			end else if (in_flag == SF_SPACE) begin
				pre_q <= 8'h20;
			end else begin
				pre_q <= 8'h2b;
			end
		end else if (cmd.go) begin
			case (cmd.dp)
				DP_DABBLE: begin
					dig_q[63:24] <= {bcd_adj[38:0], bin_q[31]};
					bin_q <= {bin_q[30:0], 1'b0};
					it_q <= it_q + 5'd1;
				end
				DP_SKIP: begin
					if (stat.skip) begin
						dig_q <= {dig_q[59:0], 4'd0};
						cnt_q <= cnt_q - 5'd1;
					end
				end
				DP_SHIFT: begin
					dig_q <= {dig_q[59:0], 4'd0};
					cnt_q <= cnt_q - 5'd1;
				end
				default: begin
				end
			endcase
		end
	end

	assign emit_fire = cmd.go && cmd.emit_act;

	always_comb begin
		case (cmd.emit)
			E_SIGN: begin
				emit_chr = pre_q;
				emit_last = 1'b0;
			end
			E_DIGIT: begin
				emit_chr = digit_char(dig_q[63:60], upper_q);
				emit_last = (cnt_q == 5'd1);
			end
			default: begin
				emit_chr = cmd.chr;
				emit_last = cmd.last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= emit_chr;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

endmodule
`default_nettype wire

>>> hw/rtl/iaf_seq.sv
// microcode sequencer: step counter, control store and branch logic
`default_nettype none
module iaf_seq
	import iaf_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output logic  fetch,
	output cmd_t  cmd
);

	logic [PcW-1:0] pc_q;
	logic [PcW-1:0] pc_nxt;
	logic [PcW-1:0] disp;
	ctl_t           w;
	logic           cond_t;
	logic           emit_act;
	logic           go;

	assign w = ucode(pc_q);
	assign fetch = (pc_q == A_FETCH);

	always_comb begin
		case (stat.op)
			OP_SDEC, OP_UDEC: disp = A_DABBLE;
			OP_HEXL, OP_HEXU: disp = A_SKIP;
			OP_PTR:           disp = A_PTR;
			default:          disp = A_FETCH;
		endcase
	end

	always_comb begin
		case (w.cond)
			C_ALWAYS:    cond_t = 1'b1;
			C_INPUT:     cond_t = stat.in_valid;
			C_ITER_MORE: cond_t = !stat.iter_last;
			C_SKIP:      cond_t = stat.skip;
			C_MORE:      cond_t = stat.more;
			C_ZERO:      cond_t = stat.val_zero;
			default:     cond_t = 1'b0;
		endcase
	end

	// a step that emits waits for room in the output register
	assign emit_act = (w.emit == E_CONST) || (w.emit == E_DIGIT) ||
		((w.emit == E_SIGN) && stat.pre_v);
	assign go = (w.cond == C_INPUT) ? stat.in_valid : (!emit_act || stat.out_free);

	always_comb begin
		if (!go) begin
			pc_nxt = pc_q;
		end else if (w.cond == C_INPUT) begin
			pc_nxt = disp;
		end else begin
			pc_nxt = cond_t ? w.target : w.alt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_FETCH;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	assign cmd.accept = fetch && stat.in_valid;
	assign cmd.go = go;
	assign cmd.emit_act = emit_act;
	assign cmd.emit = w.emit;
	assign cmd.chr = w.chr;
	assign cmd.last = w.last;
	assign cmd.dp = w.dp;

endmodule
`default_nettype wire

>>> dv/ascii_char_checker.sv
// transfer monitor, character predictor and compare for the integer ascii formatter
`timescale 1ns / 100ps
`default_nettype none
module ascii_char_checker
	import iaf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [63:0] s_tdata,   // [63:0] value
	input  wire  [4:0]  s_tuser,   // [2:0] operation, [4:3] sign_flag
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [7:0]  m_tdata,   // [7:0] character
	input  wire         m_tlast,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} out_char_t;

	out_char_t expected_chars[$];
	out_char_t oldest;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// builds the printed form of one item and queues its characters
	function automatic void predict_chars(input logic [63:0] value, input logic [2:0] op,
		input logic [1:0] flag);
		logic [7:0] text[$];
		logic [7:0] digits[$];
		logic [31:0] mag;
		logic [31:0] digit;
		logic [63:0] rest;
		string lower_hex;
		string upper_hex;
		string nil_text;
		lower_hex = "0123456789abcdef";
		upper_hex = "0123456789ABCDEF";
		nil_text = "(nil)";
		case (op)
			OP_SDEC, OP_UDEC: begin
				mag = value[31:0];
				if (op == OP_SDEC && value[31]) begin
					text.push_back("-");
					mag = 32'd0 - value[31:0];
				end else if (op == OP_SDEC && value[31:0] != 32'd0) begin
					if (flag == SF_SPACE) begin
						text.push_back(" ");
					end else if (flag == SF_PLUS) begin
						text.push_back("+");
					end
				end
				do begin
					digit = mag % 32'd10;
					digits.push_front(8'h30 + digit[7:0]);
					mag = mag / 32'd10;
				end while (mag != 32'd0);
			end
			OP_HEXL, OP_HEXU, OP_PTR: begin
				if (op == OP_PTR && value == 64'd0) begin
					for (int i = 0; i < nil_text.len(); i++) begin
						text.push_back(nil_text[i]);
					end
				end else begin
					if (op == OP_PTR) begin
						text.push_back("0");
						text.push_back("x");
					end
					rest = value;
					do begin
						digits.push_front(op == OP_HEXU ? upper_hex[rest[3:0]] : lower_hex[rest[3:0]]);
						rest = rest >> 4;
					end while (rest != 64'd0);
				end
			end
			default: begin
				// unused codes print nothing
			end
		endcase
		foreach (digits[i]) begin
			text.push_back(digits[i]);
		end
		foreach (text[i]) begin
			expected_chars.push_back('{chr: text[i], last: (i == text.size() - 1)});
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// output register cannot hold a char of an item taken on this same edge
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %h last %b", m_tdata, m_tlast));
				end else begin
					oldest = expected_chars.pop_front();
					if (m_tdata !== oldest.chr) begin
						report_mismatch($sformatf("char %h, expected %h", m_tdata, oldest.chr));
					end
					if (m_tlast !== oldest.last) begin
						report_mismatch($sformatf("last %b on char %h, expected %b",
							m_tlast, m_tdata, oldest.last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_chars(s_tdata, s_tuser[2:0], s_tuser[4:3]);
			end
		end
		pending <= expected_chars.size();
	end

endmodule
`default_nettype wire

>>> dv/integer_ascii_formatter_tb.sv
// stimulus, handshake pacing and verdict for the integer ascii formatter
`timescale 1ns / 100ps
`default_nettype none
module integer_ascii_formatter_tb;
	import iaf_pkg::*;

	localparam logic [1:0] SF_NONE = 2'd0;
	localparam logic [1:0] SF_UNUSED = 2'd3;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int PHASE_ITEMS = 62;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [63:0] value
	logic [4:0]  s_tuser = '0;   // [2:0] operation, [4:3] sign_flag
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] character
	logic        m_tlast;

	int mismatches;
	int pending;
	int send_idle = 0;
	int recv_stall = 0;

	integer_ascii_formatter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ascii_char_checker char_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_value(input logic [63:0] value, input logic [2:0] op,
		input logic [1:0] flag);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= {flag, op};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(4))
			0: v = v;
			1: v = 64'($urandom_range(0, 20));
			// varies digit count
			2: v = v >> $urandom_range(0, 63);
			3: begin
				case ($urandom_range(5))
					0: v[31:0] = 32'h0000_0000;
					1: v[31:0] = 32'h0000_0001;
					2: v[31:0] = 32'h7fff_ffff;
					3: v[31:0] = 32'h8000_0000;
					4: v[31:0] = 32'h8000_0001;
					default: v[31:0] = 32'hffff_ffff;
				endcase
			end
			default: v[31:0] = 32'd0 - $urandom_range(1, 1000);
		endcase
		return v;
	endfunction

	initial begin
		logic [63:0] value;
		logic [2:0] op;
		logic [1:0] flag;
		int counted;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edges of the fields and every special form, no idling
		send_value(64'd0, OP_SDEC, SF_SPACE);
		send_value(64'd0, OP_SDEC, SF_PLUS);
		send_value(64'h0000_0000_8000_0000, OP_SDEC, SF_PLUS);
		send_value(64'hffff_ffff_ffff_ffff, OP_SDEC, SF_SPACE);
		send_value(64'h0000_0000_7fff_ffff, OP_SDEC, SF_PLUS);
		send_value(64'd123, OP_SDEC, SF_SPACE);
		send_value(64'd5, OP_SDEC, SF_UNUSED);
		send_value(64'd9, OP_SDEC, SF_NONE);
		send_value(64'hffff_ffff_0000_002a, OP_SDEC, SF_NONE);
		send_value(64'h0000_0000_ffff_ffff, OP_UDEC, SF_PLUS);
		send_value(64'd0, OP_UDEC, SF_NONE);
		send_value(64'h1234_5678_0000_0010, OP_UDEC, SF_SPACE);
		send_value(64'd0, OP_HEXL, SF_NONE);
		send_value(64'hffff_ffff_ffff_ffff, OP_HEXL, SF_PLUS);
		send_value(64'hfedc_ba98_7654_3210, OP_HEXU, SF_NONE);
		send_value(64'd10, OP_HEXU, SF_SPACE);
		send_value(64'd0, OP_HEXU, SF_NONE);
		send_value(64'd0, OP_PTR, SF_PLUS);
		send_value(64'hffff_ffff_ffff_ffff, OP_PTR, SF_NONE);
		send_value(64'd1, OP_PTR, SF_NONE);
		send_value(64'h0abc_0000_0000_0000, OP_PTR, SF_UNUSED);
		send_value(64'd77, OP_UNUSED_LO, SF_NONE);
		send_value(64'd0, OP_UNUSED_MID, SF_PLUS);
		send_value(64'hffff_ffff_ffff_ffff, OP_UNUSED_HI, SF_UNUSED);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 82; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 82; end
				default: begin send_idle = 19; recv_stall = 19; end
			endcase
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				value = pick_value();
				flag = 2'($urandom_range(0, 3));
				if ($urandom_range(99) < 5) begin
					op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				end else begin
					op = 3'($urandom_range(OP_SDEC, OP_PTR));
					counted++;
				end
				send_value(value, op, flag);
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		// room for a stray char past the last expected one
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("** integer_ascii_formatter: PASSED **");
		end else begin
			$display("** integer_ascii_formatter: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d chars outstanding", pending);
		$display("** integer_ascii_formatter: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/iaf_pkg.sv
hw/rtl/iaf_seq.sv
hw/rtl/integer_ascii_formatter.sv
dv/ascii_char_checker.sv
dv/integer_ascii_formatter_tb.sv
